// ===== hdl/bar_energy_phrase_scorer_unit_macros.svh =====
// Assertion macros for the bar energy phrase scorer.
// The macros expect clk_i and rst_ni in the scope where they are used.
`ifndef BAR_ENERGY_PHRASE_SCORER_UNIT_MACROS_SVH
`define BAR_ENERGY_PHRASE_SCORER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bep_pkg.sv =====
// Package of the bar energy phrase scorer: widths, constants, item types,
// controller states and the command and status structs. No dependencies.
`timescale 1ns / 1ps

package bep_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int BAR_W       = 23;
  localparam int COUNT_W     = 22;
  localparam int SQ_W        = 53;
  localparam int ENERGY_W    = (SQ_W + 1) / 2;
  localparam int SQRT_RAD_W  = 2 * ENERGY_W;
  localparam int BAR_IDX_W   = 16;
  localparam int BARS_OUT_W  = 4;
  localparam int CONF_W      = 16;

  localparam logic [BAR_W-1:0]  BAR_SAMPLES_RESET = 23'd88200;
  localparam logic [BAR_W-1:0]  BAR_SAMPLES_MAX   = 23'd4194304;
  localparam logic [CONF_W-1:0] CONF_MIN          = 16'd9830;
  localparam logic [CONF_W-1:0] CONF_MAX          = 16'd32768;

  localparam int PHRASE_BARS_DEF = 8;
  localparam int WINDOW_BARS_DEF = 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } bep_in_t;

  typedef struct packed {
    logic [BAR_IDX_W-1:0]  phrase_start_bar;
    logic [BARS_OUT_W-1:0] phrase_bars;
    logic [CONF_W-1:0]     confidence;
  } bep_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_DIV_E,
    S_WAIT_E,
    S_SQRT,
    S_WAIT_S,
    S_BAR,
    S_PREP,
    S_DIV_C,
    S_WAIT_C,
    S_OUT,
    S_CLR
  } bep_state_e;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic div_start_e;
    logic div_start_c;
    logic sqrt_start;
    logic bar_update;
    logic conf_prep;
    logic out_load;
    logic track_clear;
  } bep_cmd_t;

  typedef struct packed {
    logic bar_end;
    logic last;
    logic has_bars;
    logic phrase_full;
    logic div_busy;
    logic sqrt_busy;
  } bep_sts_t;

endpackage

// ===== hdl/bep_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the bar energy
// and the confidence paths. Depends on bep_pkg.
`timescale 1ns / 1ps

module bep_div
  import bep_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_W-1:0]  dividend_i,
  input  logic [BAR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [SQ_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(SQ_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]  quo_q, quo_d;
  logic [BAR_W-1:0] rem_q, rem_d;
  logic [BAR_W-1:0] dvs_q, dvs_d;
  logic [BAR_W:0]   rem_sh;
  logic [BAR_W:0]   diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[SQ_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SQ_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = diff[BAR_W-1:0];
        quo_d = {quo_q[SQ_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[BAR_W-1:0];
        quo_d = {quo_q[SQ_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/bep_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on bep_pkg.
`timescale 1ns / 1ps

module bep_sqrt
  import bep_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SQ_W-1:0]     radicand_i,
  output logic                busy_o,
  output logic [ENERGY_W-1:0] root_o
);

  localparam int CNT_W = $clog2(ENERGY_W + 1);
  localparam int REM_W = ENERGY_W + 3;

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SQRT_RAD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ENERGY_W-1:0]   root_q, root_d;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[SQRT_RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ENERGY_W);
      rad_d  = SQRT_RAD_W'(radicand_i);
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[SQRT_RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ENERGY_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ENERGY_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== hdl/bep_datapath.sv =====
// Datapath of the bar energy phrase scorer: bar accumulator, window sums,
// confidence operands and result register. Uses bep_pkg, bep_div, bep_sqrt.
`timescale 1ns / 1ps

module bep_datapath
  import bep_pkg::*;
#(
  parameter int PHRASE_BARS = PHRASE_BARS_DEF,
  parameter int WINDOW_BARS = WINDOW_BARS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BAR_W-1:0] cfg_wdata_i,
  input  bep_in_t          in_data_i,
  input  bep_cmd_t         cmd_i,
  output bep_sts_t         sts_o,
  output bep_out_t         out_data_o
);

  localparam int SUM_W  = ENERGY_W + $clog2(WINDOW_BARS);
  localparam int CNT_W  = $clog2(WINDOW_BARS + 1);
  localparam int POS_W  = (WINDOW_BARS > 1) ? $clog2(WINDOW_BARS) : 1;
  localparam int BARS_W = $clog2(PHRASE_BARS + 1);
  localparam int PROD_W = SUM_W + CNT_W;
  localparam int NUM_W  = PROD_W + 4;
  localparam int DEN_W  = 2 * CNT_W;

  logic [BAR_W-1:0]           bar_samples_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic [COUNT_W-1:0]         count_q;
  logic [SQ_W-1:0]            sqsum_q;
  logic [BAR_IDX_W-1:0]       bar_index_q;
  logic [BARS_W-1:0]          bars_q;
  logic [SUM_W-1:0]           before_sum_q;
  logic [CNT_W-1:0]           before_cnt_q;
  logic [SUM_W-1:0]           early_sum_q;
  logic [SUM_W-1:0]           late_sum_q;
  logic [CNT_W-1:0]           hist_cnt_q;
  logic [POS_W-1:0]           hist_pos_q;
  logic [ENERGY_W-1:0]        hist_q [WINDOW_BARS];
  logic [NUM_W-1:0]           conf_num_q;
  logic [DEN_W-1:0]           conf_den_q;
  bep_out_t                   out_q;

  logic [BAR_W-1:0]       cfg_val;
  logic signed [31:0]     square;
  logic [BAR_W-1:0]       count_inc;
  logic                   div_start;
  logic [SQ_W-1:0]        div_dividend;
  logic [BAR_W-1:0]       div_divisor;
  logic                   div_busy;
  logic [SQ_W-1:0]        div_quot;
  logic                   sqrt_busy;
  logic [ENERGY_W-1:0]    energy;
  logic                   win_open;
  logic                   hist_full;
  logic [SUM_W-1:0]       early_base;
  logic [CNT_W-1:0]       ce;
  logic [CNT_W-1:0]       cb;
  logic [PROD_W-1:0]      prod_a;
  logic [PROD_W-1:0]      prod_b;
  logic [PROD_W-1:0]      num;
  logic [CONF_W-1:0]      conf;

  always_comb begin
    cfg_val = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      cfg_val = BAR_W'(1);
    end else if (cfg_wdata_i > BAR_SAMPLES_MAX) begin
      cfg_val = BAR_SAMPLES_MAX;
    end
  end

  assign square    = sample_q * sample_q;
  assign count_inc = {1'b0, count_q} + 1'b1;

  assign div_start    = cmd_i.div_start_e | cmd_i.div_start_c;
  assign div_dividend = cmd_i.div_start_c ? SQ_W'(conf_num_q) : sqsum_q;
  assign div_divisor  = cmd_i.div_start_c ? BAR_W'(conf_den_q) : bar_samples_q;

  bep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  bep_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (div_quot),
    .busy_o     (sqrt_busy),
    .root_o     (energy)
  );

  assign win_open   = int'(bars_q) < WINDOW_BARS;
  assign hist_full  = int'(hist_cnt_q) >= WINDOW_BARS;
  assign early_base = (bars_q == '0) ? '0 : early_sum_q;

  always_comb begin
    ce     = win_open ? CNT_W'(bars_q) : CNT_W'(WINDOW_BARS);
    cb     = (before_cnt_q == '0) ? CNT_W'(1) : before_cnt_q;
    prod_a = PROD_W'(early_sum_q) * PROD_W'(cb);
    prod_b = PROD_W'(before_sum_q) * PROD_W'(ce);
    num    = (prod_a > prod_b) ? (prod_a - prod_b) : (prod_b - prod_a);
  end

  always_comb begin
    if (div_quot < SQ_W'(CONF_MIN)) begin
      conf = CONF_MIN;
    end else if (div_quot > SQ_W'(CONF_MAX)) begin
      conf = CONF_MAX;
    end else begin
      conf = div_quot[CONF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_samples_q <= BAR_SAMPLES_RESET;
      count_q       <= '0;
      sqsum_q       <= '0;
      bar_index_q   <= '0;
      bars_q        <= '0;
      before_sum_q  <= '0;
      before_cnt_q  <= '0;
      early_sum_q   <= '0;
      late_sum_q    <= '0;
      hist_cnt_q    <= '0;
      hist_pos_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        bar_samples_q <= cfg_val;
      end
      if (cmd_i.track_clear) begin
        count_q      <= '0;
        sqsum_q      <= '0;
        bar_index_q  <= '0;
        bars_q       <= '0;
        before_sum_q <= '0;
        before_cnt_q <= '0;
        early_sum_q  <= '0;
        late_sum_q   <= '0;
        hist_cnt_q   <= '0;
        hist_pos_q   <= '0;
      end else begin
        if (cmd_i.accumulate) begin
          sqsum_q <= sqsum_q + SQ_W'($unsigned(square));
          count_q <= (count_inc >= bar_samples_q) ? '0 : count_inc[COUNT_W-1:0];
        end
        if (cmd_i.div_start_e) begin
          sqsum_q <= '0;
        end
        if (cmd_i.bar_update) begin
          if (bars_q == '0) begin
            before_sum_q <= late_sum_q;
            before_cnt_q <= hist_cnt_q;
          end
          early_sum_q <= win_open ? (early_base + SUM_W'(energy)) : early_base;
          if (hist_full) begin
            late_sum_q <= late_sum_q - SUM_W'(hist_q[hist_pos_q]) + SUM_W'(energy);
          end else begin
            late_sum_q <= late_sum_q + SUM_W'(energy);
            hist_cnt_q <= hist_cnt_q + 1'b1;
          end
          hist_pos_q  <= (hist_pos_q == POS_W'(WINDOW_BARS - 1)) ? '0 : hist_pos_q + 1'b1;
          bars_q      <= bars_q + 1'b1;
          bar_index_q <= bar_index_q + 1'b1;
        end
        if (cmd_i.out_load) begin
          bars_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= in_data_i.sample;
      last_q   <= in_data_i.last;
    end
    if (cmd_i.bar_update) begin
      hist_q[hist_pos_q] <= energy;
    end
    if (cmd_i.conf_prep) begin
      conf_num_q <= (NUM_W'(num) << 3) + (NUM_W'(num) << 1);
      conf_den_q <= DEN_W'(ce) * DEN_W'(cb);
    end
    if (cmd_i.out_load) begin
      out_q.phrase_start_bar <= bar_index_q - BAR_IDX_W'(bars_q);
      out_q.phrase_bars      <= BARS_OUT_W'(bars_q);
      out_q.confidence       <= conf;
    end
  end

  always_comb begin
    sts_o.bar_end     = count_inc >= bar_samples_q;
    sts_o.last        = last_q;
    sts_o.has_bars    = bars_q != '0;
    sts_o.phrase_full = (int'(bars_q) + 1) >= PHRASE_BARS;
    sts_o.div_busy    = div_busy;
    sts_o.sqrt_busy   = sqrt_busy;
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/bep_ctrl.sv =====
// Controller of the bar energy phrase scorer: sequences sample intake, bar
// close, phrase emit and the result valid flag. Depends on bep_pkg and bar_energy_phrase_scorer_unit_macros.svh.
`timescale 1ns / 1ps
`include "bar_energy_phrase_scorer_unit_macros.svh"

module bep_ctrl
  import bep_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  bep_sts_t sts_i,
  output bep_cmd_t cmd_o
);

  bep_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        priority if (sts_i.bar_end) begin
          state_d = S_DIV_E;
        end else if (sts_i.last && sts_i.has_bars) begin
          state_d = S_PREP;
        end else if (sts_i.last) begin
          state_d = S_CLR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV_E: state_d = S_WAIT_E;
      S_WAIT_E: begin
        if (!sts_i.div_busy) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: state_d = S_WAIT_S;
      S_WAIT_S: begin
        if (!sts_i.sqrt_busy) begin
          state_d = S_BAR;
        end
      end
      S_BAR: begin
        if (sts_i.phrase_full || sts_i.last) begin
          state_d = S_PREP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PREP: state_d = S_DIV_C;
      S_DIV_C: state_d = S_WAIT_C;
      S_WAIT_C: begin
        if (!sts_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_CLR: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = 1'b1;
      end
      S_ACC:   cmd_o.accumulate  = 1'b1;
      S_DIV_E: cmd_o.div_start_e = 1'b1;
      S_SQRT:  cmd_o.sqrt_start  = 1'b1;
      S_BAR:   cmd_o.bar_update  = 1'b1;
      S_PREP:  cmd_o.conf_prep   = 1'b1;
      S_DIV_C: cmd_o.div_start_c = 1'b1;
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.track_clear = sts_i.last;
        end
      end
      S_CLR:   cmd_o.track_clear = 1'b1;
      S_WAIT_E, S_WAIT_S, S_WAIT_C: begin
        cmd_o = '0;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BEP_ASSERT_SAME(a_load_into_free_slot, cmd_o.out_load, !out_valid_q || !out_stall_i, "result overwritten while stalled")
  `BEP_ASSERT_NEXT(a_accept_then_acc, accept, state_q == S_ACC, "accepted item not accumulated")
  `BEP_ASSERT_SAME(a_div_start_idle, cmd_o.div_start_e || cmd_o.div_start_c, !sts_i.div_busy, "divider started while busy")
  `BEP_ASSERT_NEXT(a_clear_then_idle, cmd_o.track_clear, state_q == S_IDLE, "track clear not followed by idle")

endmodule

// ===== hdl/bar_energy_phrase_scorer_unit.sv =====
// Each sample item is captured at intake, then accumulated; no new item is taken
// before it is accumulated. A bar close runs the 53-step shared divider, then the 27-step root.
// An emitted phrase then prepares the confidence operands and divides on the same
// divider; the result then sits in the output register until taken.
// Reset: track state clears at once, bar_samples returns to 88200, no clear pass.
// Top level of the bar energy phrase scorer; uses bep_pkg, bep_ctrl, bep_datapath.
`timescale 1ns / 1ps

module bar_energy_phrase_scorer_unit
  import bep_pkg::*;
#(
  parameter int PHRASE_BARS = PHRASE_BARS_DEF,
  parameter int WINDOW_BARS = WINDOW_BARS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BAR_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bep_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bep_out_t         out_data_o
);

  bep_cmd_t cmd;
  bep_sts_t sts;

  bep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bep_datapath #(
    .PHRASE_BARS (PHRASE_BARS),
    .WINDOW_BARS (WINDOW_BARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/bar_energy_phrase_scorer_unit_tb.sv =====
// Self-checking testbench for bar_energy_phrase_scorer_unit: drives sample items with random
// gaps and output stalls, predicts every phrase in a scoreboard class and compares fields.
// Depends on bep_pkg and the bar_energy_phrase_scorer_unit RTL.
`timescale 1ns / 1ps

module bar_energy_phrase_scorer_unit_tb;
  import bep_pkg::*;

  localparam int PHRASE_LEN  = PHRASE_BARS_DEF;
  localparam int WINDOW_LEN  = WINDOW_BARS_DEF;
  localparam int SETTLE_CYC  = 300;
  localparam int HOLD_CYC    = 3000;
  localparam int MODE_QUOTA  = 560;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef enum int {TONE_FULL, TONE_STEADY, TONE_SPREAD} tone_e;

  class phrase_scoreboard;
    int unsigned       bar_len;
    int unsigned       in_bar;
    longint unsigned   sq_acc;
    int unsigned       bar_no;
    int unsigned       phrase_fill;
    int unsigned       prev_sum;
    int unsigned       prev_cnt;
    int unsigned       head_sum;
    int unsigned       tail_sum;
    int unsigned       tail_hist[WINDOW_LEN];
    int unsigned       tail_cnt;
    int unsigned       tail_pos;
    bep_out_t          pending[$];
    int                errors;

    function new();
      bar_len = BAR_SAMPLES_RESET;
      errors  = 0;
      clear_track();
    endfunction

    function void clear_track();
      in_bar      = 0;
      sq_acc      = 0;
      bar_no      = 0;
      phrase_fill = 0;
      prev_sum    = 0;
      prev_cnt    = 0;
      head_sum    = 0;
      tail_sum    = 0;
      tail_cnt    = 0;
      tail_pos    = 0;
      foreach (tail_hist[i]) tail_hist[i] = 0;
    endfunction

    function void set_bar(logic [BAR_W-1:0] v);
      if (v == '0) begin
        bar_len = 1;
      end else if (v > BAR_SAMPLES_MAX) begin
        bar_len = BAR_SAMPLES_MAX;
      end else begin
        bar_len = v;
      end
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        c = r | (64'd1 << i);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function void close_phrase();
      longint unsigned ce;
      longint unsigned cb;
      longint unsigned a;
      longint unsigned b;
      longint unsigned num;
      longint unsigned conf;
      bep_out_t        e;
      ce = (phrase_fill < WINDOW_LEN) ? phrase_fill : WINDOW_LEN;
      if (ce == 0) ce = 1;
      cb = prev_cnt;
      if (cb == 0) begin
        conf = (64'd10 * head_sum) / ce;
      end else begin
        a    = longint'(head_sum) * cb;
        b    = longint'(prev_sum) * ce;
        num  = (a > b) ? a - b : b - a;
        conf = (64'd10 * num) / (ce * cb);
      end
      if (conf < CONF_MIN) conf = CONF_MIN;
      if (conf > CONF_MAX) conf = CONF_MAX;
      e.phrase_start_bar = 16'(bar_no - phrase_fill);
      e.phrase_bars      = 4'(phrase_fill);
      e.confidence       = 16'(conf);
      pending = {pending, e};
      phrase_fill = 0;
    endfunction

    function void note_sample(bep_in_t d);
      longint          sv;
      int unsigned     energy;
      bit              fired;
      sv     = $signed(d.sample);
      sq_acc = sq_acc + longint'(sv * sv);
      in_bar++;
      fired  = 1'b0;
      if (in_bar >= bar_len) begin
        energy = 32'(floor_root(sq_acc / bar_len));
        in_bar = 0;
        sq_acc = 0;
        if (phrase_fill == 0) begin
          prev_sum = tail_sum;
          prev_cnt = tail_cnt;
          head_sum = 0;
        end
        if (phrase_fill < WINDOW_LEN) head_sum += energy;
        if (tail_cnt >= WINDOW_LEN) begin
          tail_sum -= tail_hist[tail_pos];
        end else begin
          tail_cnt++;
        end
        tail_hist[tail_pos] = energy;
        tail_sum += energy;
        tail_pos = (tail_pos + 1) % WINDOW_LEN;
        phrase_fill++;
        bar_no = (bar_no + 1) & 32'hFFFF;
        if (phrase_fill >= PHRASE_LEN) begin
          close_phrase();
          fired = 1'b1;
        end
      end
      if (!fired && d.last && phrase_fill > 0) close_phrase();
      if (d.last) clear_track();
    endfunction

    function void check_phrase(bep_out_t got);
      bep_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected phrase, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.phrase_start_bar !== want.phrase_start_bar) begin
        $display("%0t: phrase_start_bar expected %0d actual %0d", $time,
                 want.phrase_start_bar, got.phrase_start_bar);
        errors++;
      end
      if (got.phrase_bars !== want.phrase_bars) begin
        $display("%0t: phrase_bars expected %0d actual %0d", $time,
                 want.phrase_bars, got.phrase_bars);
        errors++;
      end
      if (got.confidence !== want.confidence) begin
        $display("%0t: confidence expected %0d actual %0d", $time,
                 want.confidence, got.confidence);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [BAR_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  bep_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  bep_out_t         out_data_o;

  phrase_scoreboard sb = new();

  int          send_pct  = 22;
  int          recv_pct  = 54;
  int          hold_tag  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          sent      = 0;
  int unsigned cycle_cnt = 0;
  int unsigned cur_bar   = BAR_SAMPLES_RESET;
  bit          open_bar  = 1'b0;
  tone_e       tone      = TONE_SPREAD;
  int          tone_amp  = 1000;

  bar_energy_phrase_scorer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_phrase(out_data_o);
  end

  function automatic void pick_tone();
    int r;
    tone = tone_e'($urandom_range(0, 2));
    r = $urandom_range(0, 9);
    if (r < 3) begin
      tone_amp = $urandom_range(0, 300);
    end else if (r < 7) begin
      tone_amp = $urandom_range(1000, 32767);
    end else begin
      tone_amp = 32767;
    end
  endfunction

  function automatic logic signed [15:0] gen_sample();
    logic signed [15:0] s;
    case (tone)
      TONE_FULL: begin
        s = 16'($urandom());
      end
      TONE_STEADY: begin
        s = $urandom_range(0, 1) ? 16'(tone_amp) : 16'(-tone_amp);
      end
      default: begin
        s = 16'(int'($urandom_range(0, 2 * tone_amp)) - tone_amp);
      end
    endcase
    return s;
  endfunction

  task automatic send_sample(input logic signed [15:0] s, input logic lst);
    bep_in_t item;
    item.sample = s;
    item.last   = lst;
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(item);
    sent++;
    open_bar = !lst;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_bar(input logic [BAR_W-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_bar(v);
    cur_bar = sb.bar_len;
  endtask

  task automatic run_track(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 31) == 0) pick_tone();
      send_sample(gen_sample(), (close && i == len - 1) || ($urandom_range(0, 199) == 0));
    end
  endtask

  task automatic run_mode(input int s_pct, input int r_pct, input bit squeeze);
    int          start;
    int          r;
    int unsigned v;
    int          span;
    send_pct = s_pct;
    recv_pct = r_pct;
    start    = sent;
    if (squeeze) begin
      write_bar(1);
      hold_tag++;
      run_track(80, 1'b1);
    end
    while (sent - start < MODE_QUOTA) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        v = 0;
      end else if (r < 73) begin
        v = $urandom_range(1, 6);
      end else if (r < 93) begin
        v = $urandom_range(7, 16);
      end else begin
        v = $urandom_range(17, 64);
      end
      if (open_bar && (v == 0 ? 1 : v) < cur_bar) v = cur_bar;
      write_bar(v);
      span = (cur_bar * 18 > 400) ? 400 : cur_bar * 18;
      run_track($urandom_range(1, span), $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero bar length acts as one; loud window before a quiet partial phrase.
    write_bar(0);
    repeat (4) send_sample(16'sd0, 1'b0);
    repeat (4) send_sample(-16'sd32768, 1'b0);
    repeat (3) send_sample(16'sd100, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd5, 1'b1);

    // Shorten the bar while one is open, then end the track on a full phrase.
    write_bar(3);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b0);
    write_bar(1);
    send_sample(16'sd1000, 1'b0);
    for (int i = 0; i < 7; i++) send_sample(16'(i * 4000 - 12000), i == 6);

    // Oversized bar length clamps to the maximum; the partial bar is dropped.
    write_bar(23'h7FFFFF);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1, 1'b1);

    pick_tone();
    run_mode(22, 54, 1'b0);
    run_mode(54, 22, 1'b0);
    run_mode(0, 0, 1'b1);

    settle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
